[rtl/core/kvtlp_pkg.sv]
// Package: shared types and constants for the telemetry line parser.
`timescale 1ns / 1ps
`default_nettype none
package kvtlp_pkg;

  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [3:0] IdChecksum = 4'd12;
  localparam logic [3:0] IdNone     = 4'd15;
  localparam int unsigned KeyBytes  = 8;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_MIN_FIELDS   = 1'b0,
    CFG_VALID_WINDOW = 1'b1
  } cfg_idx_e;

  // Front-to-back request: one classified item.
  typedef struct packed {
    logic        tick;
    logic        line_end;
    logic [3:0]  key_id;
    logic [31:0] value;
  } evt_t;

  // Key lookup over an 8-byte key buffer; byte 0 is the first char.
  function automatic logic [3:0] key_lookup(input logic [63:0] k, input logic [3:0] len);
    logic [3:0] id;
    id = IdNone;
    case (len)
      4'd1: begin
        if (k[7:0] == "V") id = 4'd0;
        else if (k[7:0] == "I") id = 4'd1;
      end
      4'd2: begin
        if (k[15:0] == {"S", "C"}) id = 4'd4;
        else if (k[15:0] == {"L", "I"}) id = 4'd6;
      end
      4'd3: begin
        case (k[23:0])
          {"V", "P", "V"}: id = 4'd2;
          {"V", "P", "P"}: id = 4'd3;
          {"R", "R", "E"}: id = 4'd5;
          {"9", "1", "H"}: id = 4'd7;
          {"0", "2", "H"}: id = 4'd8;
          {"1", "2", "H"}: id = 4'd9;
          {"2", "2", "H"}: id = 4'd10;
          {"3", "2", "H"}: id = 4'd11;
          default: id = IdNone;
        endcase
      end
      4'd8: begin
        if (k == {"m", "u", "s", "k", "c", "e", "h", "C"}) id = IdChecksum;
      end
      default: id = IdNone;
    endcase
    return id;
  endfunction

endpackage
`default_nettype wire

[rtl/core/kvtlp_if.sv]
// Interfaces: valid/ready request channels for items, results and config.
`timescale 1ns / 1ps
`default_nettype none
interface kvtlp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface kvtlp_out_if;
  logic        valid;
  logic        ready;
  logic        field_update;
  logic [3:0]  field_id;
  logic signed [31:0] field_value;
  logic [2:0]  charge_state;
  logic        block_end;
  logic        block_accepted;
  logic        data_valid;
  modport source (output valid, field_update, field_id, field_value, charge_state,
                  block_end, block_accepted, data_valid, input ready);
  modport sink (input valid, field_update, field_id, field_value, charge_state,
                block_end, block_accepted, data_valid, output ready);
endinterface

interface kvtlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/kvtlp_front.sv]
// Front end: line assembly, key capture and on-the-fly number parsing.
`timescale 1ns / 1ps
`default_nettype none
module kvtlp_front #(
  parameter int unsigned MaxLine = 64,
  parameter int unsigned MaxKey  = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       command_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            evt_valid_o,
  input  wire logic       evt_ready_i,
  output kvtlp_pkg::evt_t evt_o
);
  localparam int unsigned LenW = $clog2(MaxLine + 1);
  localparam int unsigned KlW  = $clog2(MaxKey + 1);

  logic [LenW-1:0] len_q, len_d;
  logic [63:0]     key_q, key_d;
  logic [KlW-1:0]  klen_q, klen_d;
  logic            long_q, long_d, tab_q, tab_d, neg_q, neg_d;
  kvtlp_pkg::phase_e ph_q, ph_d;
  logic [31:0]     acc_q, acc_d;
  logic [35:0]     mul;
  logic            fire, is_dig, is_sp;
  logic [3:0]      kid;
  logic [31:0]     fval;

  assign in_ready_o  = evt_ready_i;
  assign evt_valid_o = in_valid_i;
  assign fire = in_valid_i && in_ready_o;

  assign is_dig = rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39;
  assign is_sp  = rx_byte_i == 8'h20 || rx_byte_i == 8'h09 ||
                  rx_byte_i == 8'h0B || rx_byte_i == 8'h0C;
  assign mul = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {32'd0, rx_byte_i[3:0]};

  // Key classification and value saturation: beyond 8 bytes only the long flag matters
  always_comb begin
    kid = kvtlp_pkg::IdNone;
    if (!long_q && klen_q <= KlW'(kvtlp_pkg::KeyBytes))
      kid = kvtlp_pkg::key_lookup(key_q, 4'(klen_q));
    if (len_q == '0 || !tab_q) kid = kvtlp_pkg::IdNone;
    if (neg_q) fval = 32'd0 - acc_q;
    else fval = acc_q[31] ? 32'h7FFF_FFFF : acc_q;
  end

  always_comb begin
    evt_o.tick     = command_i == kvtlp_pkg::CMD_TICK;
    evt_o.line_end = command_i == kvtlp_pkg::CMD_BYTE && rx_byte_i == kvtlp_pkg::ChLf;
    evt_o.key_id   = kid;
    evt_o.value    = fval;
    len_d = len_q; key_d = key_q; klen_d = klen_q; long_d = long_q;
    tab_d = tab_q; ph_d = ph_q; neg_d = neg_q; acc_d = acc_q;
    if (command_i == kvtlp_pkg::CMD_BYTE) begin
      if (rx_byte_i == kvtlp_pkg::ChLf) begin
        len_d = '0; key_d = '0; klen_d = '0; long_d = 1'b0; tab_d = 1'b0;
        ph_d = kvtlp_pkg::PH_SKIP; neg_d = 1'b0; acc_d = '0;
      end else if (rx_byte_i != kvtlp_pkg::ChCr && len_q < LenW'(MaxLine)) begin
        len_d = len_q + 1'b1;
        if (tab_q) begin
          if (ph_q == kvtlp_pkg::PH_SKIP && is_sp) begin
            ph_d = ph_q;
          end else if (ph_q == kvtlp_pkg::PH_SKIP &&
                       (rx_byte_i == 8'h2B || rx_byte_i == 8'h2D)) begin
            neg_d = rx_byte_i == 8'h2D;
            ph_d  = kvtlp_pkg::PH_SIGN;
          end else if (ph_q != kvtlp_pkg::PH_DONE && is_dig) begin
            acc_d = (mul > 36'h0_8000_0000) ? 32'h8000_0000 : mul[31:0];
            ph_d  = kvtlp_pkg::PH_DIGIT;
          end else begin
            ph_d = kvtlp_pkg::PH_DONE;
          end
        end else if (rx_byte_i == kvtlp_pkg::ChTab) begin
          tab_d = 1'b1;
        end else if (klen_q < KlW'(MaxKey)) begin
          if (klen_q < KlW'(kvtlp_pkg::KeyBytes))
            key_d[8*klen_q[2:0] +: 8] = rx_byte_i;
          klen_d = klen_q + 1'b1;
        end else begin
          long_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; key_q <= '0; klen_q <= '0; long_q <= 1'b0; tab_q <= 1'b0;
      ph_q <= kvtlp_pkg::PH_SKIP; neg_q <= 1'b0; acc_q <= '0;
    end else if (fire) begin
      len_q <= len_d; key_q <= key_d; klen_q <= klen_d; long_q <= long_d;
      tab_q <= tab_d; ph_q <= ph_d; neg_q <= neg_d; acc_q <= acc_d;
    end
  end
endmodule
`default_nettype wire

[rtl/core/kvtlp_queue.sv]
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module kvtlp_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  kvtlp_pkg::evt_t in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output kvtlp_pkg::evt_t out_data_o
);
  kvtlp_pkg::evt_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/core/kvtlp_back.sv]
// Back end: block bookkeeping, age timer and result register.
`timescale 1ns / 1ps
`default_nettype none
module kvtlp_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        evt_valid_i,
  output logic             evt_ready_o,
  input  kvtlp_pkg::evt_t  evt_i,
  input  wire logic [7:0]  min_fields_i,
  input  wire logic [15:0] valid_window_i,
  kvtlp_out_if.source      res
);
  logic [7:0]  cnt_q, cnt_d;
  logic        hv_q, hv_d;
  logic [15:0] age_q, age_d;
  logic [2:0]  cs_q, cs_d;
  logic        ov_q, take;
  logic        upd, bend, bacc;

  assign evt_ready_o = !ov_q || res.ready;
  assign take = evt_valid_i && evt_ready_o;

  always_comb begin
    cnt_d = cnt_q; hv_d = hv_q; age_d = age_q; cs_d = cs_q;
    upd = 1'b0; bend = 1'b0; bacc = 1'b0;
    if (evt_i.tick) begin
      if (age_q != 16'hFFFF) age_d = age_q + 16'd1;
    end else if (evt_i.line_end) begin
      if (evt_i.key_id == kvtlp_pkg::IdChecksum) begin
        bend = 1'b1;
        if (cnt_q >= min_fields_i) begin
          bacc = 1'b1; hv_d = 1'b1; age_d = '0;
        end
        cnt_d = '0;
      end else if (evt_i.key_id != kvtlp_pkg::IdNone) begin
        upd = 1'b1;
        if (evt_i.key_id <= 4'd2 && cnt_q != 8'hFF) cnt_d = cnt_q + 8'd1;
        if (evt_i.key_id == 4'd4) begin
          if (evt_i.value == 32'd0) cs_d = 3'd1;
          else if (evt_i.value >= 32'd2 && evt_i.value <= 32'd7) cs_d = evt_i.value[2:0];
          else cs_d = 3'd0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res.field_update   <= upd;
      res.field_id       <= upd ? evt_i.key_id : 4'd0;
      res.field_value    <= upd ? evt_i.value : 32'd0;
      res.charge_state   <= cs_d;
      res.block_end      <= bend;
      res.block_accepted <= bacc;
      res.data_valid     <= hv_d && (age_d < valid_window_i);
    end
  end

  assign res.valid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; hv_q <= 1'b0; age_q <= '0; cs_q <= '0; ov_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q <= cnt_d; hv_q <= hv_d; age_q <= age_d; cs_q <= cs_d;
      end
      if (take) ov_q <= 1'b1;
      else if (res.ready) ov_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[rtl/core/key_value_telemetry_line_parser.sv]
// Top level: key/value telemetry line parser.
//  channel  | dir | payload
//  in_ch    | in  | command, rx_byte
//  out_ch   | out | field_update..data_valid
//  cfg_ch   | in  | index, data (0 min_fields, 1 valid_window)
// One request per cycle sustained while out_ch is ready. A request enters the
// queue at the edge at which it is accepted, is then loaded into the back
// result register and leaves from there when out_ch is ready. Either side may
// stall alone; the 2-entry queue plus the result register hold three requests
// before the input stalls. Reset clears all line, block and age state.
`timescale 1ns / 1ps
`default_nettype none
module key_value_telemetry_line_parser #(
  parameter int unsigned MaxLine = 64,
  parameter int unsigned MaxKey  = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kvtlp_in_if.sink    in_ch,
  kvtlp_out_if.source out_ch,
  kvtlp_cfg_if.sink   cfg_ch
);
  logic [7:0]  minf_q;
  logic [15:0] win_q;
  logic        fv, fr, bv, br;
  kvtlp_pkg::evt_t fe, be;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minf_q <= 8'd3; win_q <= 16'd5000;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        kvtlp_pkg::CFG_MIN_FIELDS:   minf_q <= cfg_ch.data[7:0];
        kvtlp_pkg::CFG_VALID_WINDOW: win_q  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  kvtlp_front #(.MaxLine(MaxLine), .MaxKey(MaxKey)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .command_i(in_ch.command), .rx_byte_i(in_ch.rx_byte),
    .evt_valid_o(fv), .evt_ready_i(fr), .evt_o(fe)
  );

  kvtlp_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr), .in_data_i(fe),
    .out_valid_o(bv), .out_ready_i(br), .out_data_o(be)
  );

  kvtlp_back u_back (
    .clk_i, .rst_ni, .evt_valid_i(bv), .evt_ready_o(br), .evt_i(be),
    .min_fields_i(minf_q), .valid_window_i(win_q), .res(out_ch)
  );
endmodule
`default_nettype wire
